FILE: design/sliding_sequence_window_bitmap_top_assert.svh
// Assertion macros shared by the checker of the sliding sequence window bitmap.
`ifndef SLIDING_SEQUENCE_WINDOW_BITMAP_TOP_ASSERT_SVH
`define SLIDING_SEQUENCE_WINDOW_BITMAP_TOP_ASSERT_SVH

// Next-cycle implication, switched off while reset is high.
`define SSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SSW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/ssw_pkg.sv
// Types and constants of the sliding sequence window bitmap.
package ssw_pkg;

   // default window size in 32-bit words
   localparam int WINDOW_WORDS_DEF = 8;
   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int SEQ_W = 32;

   // request kind codes on the input tuser
   localparam logic [1:0] KIND_TEST  = 2'd0;
   localparam logic [1:0] KIND_MARK  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_TEST,
      OP_MARK,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [SEQ_W-1:0] seq;
   } queue_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_SWEEP,
      ST_SETFLAG
   } back_state_type;

endpackage

FILE: design/ssw_queue.sv
// Short FIFO of classified operations between front and back.
module ssw_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ssw_pkg::queue_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      not_empty,
   output ssw_pkg::queue_entry_type  head_entry
);
   import ssw_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   queue_entry_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == DEPTH_CNT);
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/ssw_front.sv
// Input side: takes request transfers and turns their kind into queue operations.
module ssw_front (
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,
   input  logic [1:0]                req_tuser,
   input  logic                      queue_full,
   input  logic                      init_busy,
   output logic                      push,
   output ssw_pkg::queue_entry_type  push_entry
);
   import ssw_pkg::*;

   logic take;
   logic known;

   // hold off while the queue is full or the bitmap is being cleared after reset
   assign req_tready = !queue_full && !init_busy;
   assign take       = req_tvalid && req_tready;

   // decode the kind; unused codes are consumed and dropped
   always_comb begin
      known          = 1'b1;
      push_entry.op  = OP_TEST;
      push_entry.seq = req_tdata;
      unique case (req_tuser)
         KIND_TEST:  push_entry.op = OP_TEST;
         KIND_MARK:  push_entry.op = OP_MARK;
         KIND_CLEAR: push_entry.op = OP_CLEAR;
         default:    known = 1'b0;
      endcase
   end

   assign push = take && known;

endmodule

FILE: design/ssw_back.sv
// Execution side: window bookkeeping, bitmap memory, sweeps and the result register.
module ssw_back #(
   parameter int WINDOW_WORDS = ssw_pkg::WINDOW_WORDS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_not_empty,
   input  ssw_pkg::queue_entry_type  head_entry,
   output logic                      pop,
   output logic                      init_busy,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_seen
);
   import ssw_pkg::*;

   localparam int AW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;
   localparam int CW = $clog2(WINDOW_WORDS + 1);
   localparam logic [AW:0]    WORDS_EXT = (AW+1)'(WINDOW_WORDS);
   localparam logic [AW-1:0]  LAST_WORD = AW'(WINDOW_WORDS - 1);
   localparam logic [CW-1:0]  WORDS_CNT = CW'(WINDOW_WORDS);
   localparam logic [26:0]    WORDS_27  = 27'(WINDOW_WORDS);
   localparam logic [26:0]    TOP_IDX   = 27'(WINDOW_WORDS - 1);
   localparam logic [31:0]    WIN_SPAN  = 32'(WINDOW_WORDS * 32);

   back_state_type state_ff, state_in;

   op_type        op_ff, op_in;
   logic [4:0]    bit_ff, bit_in;
   logic [31:0]   dist_ff, dist_in;
   logic [31:0]   floor_ff, floor_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] top_ff, top_in;
   logic [AW-1:0] waddr_ff, waddr_in;
   logic          slide_ff, slide_in;
   logic          init_ff, init_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_seen_ff, rsp_seen_in;

   // bitmap memory, one word per row, circular from base_ff
   logic [31:0]   mem [WINDOW_WORDS];
   logic [31:0]   rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;

   // window classification of the item held in dist_ff
   logic          below, in_window, out_stall, take_next;
   logic [31:0]   to_ceil;
   logic [26:0]   word_idx, move;
   logic          move_all;
   logic [AW:0]   phys_sum, nbase_sum;
   logic [AW-1:0] phys, nbase;
   logic [31:0]   bit_mask;

   assign below     = dist_ff[31] && (dist_ff[30:0] != '0);
   assign to_ceil   = WIN_SPAN - dist_ff;
   assign in_window = !below && (to_ceil != '0) && !to_ceil[31];
   assign word_idx  = dist_ff[31:5];
   assign phys_sum  = {1'b0, base_ff} + {1'b0, word_idx[AW-1:0]};
   assign phys      = (phys_sum >= WORDS_EXT) ? AW'(phys_sum - WORDS_EXT) : phys_sum[AW-1:0];
   assign move      = word_idx - TOP_IDX;
   assign move_all  = (move >= WORDS_27);
   assign nbase_sum = {1'b0, base_ff} + {1'b0, move[AW-1:0]};
   assign nbase     = (nbase_sum >= WORDS_EXT) ? AW'(nbase_sum - WORDS_EXT)
                                               : nbase_sum[AW-1:0];
   assign bit_mask  = 32'd1 << bit_ff;
   assign out_stall = rsp_valid_ff && !rsp_ready;
   assign take_next = queue_not_empty;

   assign init_busy = init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_seen  = rsp_seen_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_next) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            unique case (op_ff)
               OP_TEST: begin
                  if (!out_stall) state_in = (below || !in_window) ? ST_IDLE : ST_UPDATE;
               end
               OP_MARK: begin
                  if (below)          state_in = ST_IDLE;
                  else if (in_window) state_in = ST_UPDATE;
                  else                state_in = ST_SWEEP;
               end
               OP_CLEAR: state_in = ST_SWEEP;
               default:  state_in = ST_IDLE;
            endcase
         end
         ST_UPDATE: begin
            state_in = take_next ? ST_LOOKUP : ST_IDLE;
         end
         ST_SWEEP: begin
            if (cnt_ff == CW'(1)) state_in = slide_ff ? ST_SETFLAG : ST_IDLE;
         end
         ST_SETFLAG: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in        = op_ff;
      bit_in       = bit_ff;
      dist_in      = dist_ff;
      floor_in     = floor_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      waddr_in     = waddr_ff;
      slide_in     = slide_ff;
      init_in      = init_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_seen_in  = rsp_seen_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = phys;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            pop = take_next;
         end
         ST_LOOKUP: begin
            unique case (op_ff)
               OP_TEST: begin
                  if (!out_stall) begin
                     if (below || !in_window) begin
                        rsp_valid_in = 1'b1;
                        rsp_seen_in  = below;
                     end else begin
                        rd_en    = 1'b1;
                        waddr_in = phys;
                     end
                  end
               end
               OP_MARK: begin
                  if (!below && in_window) begin
                     rd_en    = 1'b1;
                     waddr_in = phys;
                  end else if (!below) begin
                     // slide up: clear the words that enter, then set the top flag
                     floor_in = floor_ff + {move, 5'd0};
                     ptr_in   = base_ff;
                     slide_in = 1'b1;
                     if (move_all) begin
                        cnt_in = WORDS_CNT;
                        top_in = (base_ff == '0) ? LAST_WORD : base_ff - 1'b1;
                     end else begin
                        cnt_in  = move[CW-1:0];
                        base_in = nbase;
                        top_in  = (nbase == '0) ? LAST_WORD : nbase - 1'b1;
                     end
                  end
               end
               OP_CLEAR: begin
                  floor_in = '0;
                  base_in  = '0;
                  ptr_in   = '0;
                  cnt_in   = WORDS_CNT;
                  slide_in = 1'b0;
               end
               default: ;
            endcase
         end
         ST_UPDATE: begin
            if (op_ff == OP_TEST) begin
               rsp_valid_in = 1'b1;
               rsp_seen_in  = rd_data_ff[bit_ff];
            end else begin
               wr_en   = 1'b1;
               wr_addr = waddr_ff;
               wr_data = rd_data_ff | bit_mask;
            end
            pop = take_next;
         end
         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = '0;
            ptr_in  = (ptr_ff == LAST_WORD) ? '0 : ptr_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) init_in = 1'b0;
         end
         ST_SETFLAG: begin
            wr_en   = 1'b1;
            wr_addr = top_ff;
            wr_data = bit_mask;
         end
         default: ;
      endcase

      // load the next operation from the queue
      if (pop) begin
         op_in   = head_entry.op;
         bit_in  = head_entry.seq[4:0];
         dist_in = head_entry.seq - floor_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         floor_ff     <= '0;
         base_ff      <= '0;
         ptr_ff       <= '0;
         cnt_ff       <= WORDS_CNT;
         slide_ff     <= 1'b0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         floor_ff     <= floor_in;
         base_ff      <= base_in;
         ptr_ff       <= ptr_in;
         cnt_ff       <= cnt_in;
         slide_ff     <= slide_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bit_ff      <= bit_in;
      dist_ff     <= dist_in;
      top_ff      <= top_in;
      waddr_ff    <= waddr_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   // bitmap memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: design/sliding_sequence_window_bitmap_top.sv
// Sliding sequence window bitmap: duplicate tracker over WINDOW_WORDS x 32 sequence flags.
// A request carries a 32-bit wrapping sequence number in tdata and its kind in tuser
// (test, mark, clear; other codes are consumed and ignored). Only a test returns a
// response, one bit in rsp_tdata[0]. A test or a mark that falls inside the window
// goes through a memory read in the back end, then the result or write-back, and the
// next item is taken from the queue with that second step; a test outside the window
// answers with no memory read. A mark above the window clears the words that enter,
// one memory row per cycle, then sets its flag in the top word; a clear clears every
// word of the window. After reset a clearing pass over all words of the window
// runs while req_tready stays low. A two-entry queue separates request intake from
// execution, and the response register lets the next item be taken while a result waits.
module sliding_sequence_window_bitmap_top #(
   parameter int WINDOW_WORDS = ssw_pkg::WINDOW_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seq_number
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_seen, [7:1] zero
);
   import ssw_pkg::*;

   queue_entry_type push_entry, head_entry;
   logic            push, queue_full, queue_not_empty, pop;
   logic            init_busy, rsp_seen;

   ssw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .init_busy  (init_busy),
      .push       (push),
      .push_entry (push_entry)
   );

   ssw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .head_entry (head_entry)
   );

   ssw_back #(
      .WINDOW_WORDS (WINDOW_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head_entry      (head_entry),
      .pop             (pop),
      .init_busy       (init_busy),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_seen        (rsp_seen)
   );

   assign rsp_tdata = {7'd0, rsp_seen};

endmodule

FILE: design/ssw_checker.sv
// Port-level checks of the sliding sequence window bitmap, bound to the top level.
`include "sliding_sequence_window_bitmap_top_assert.svh"

module ssw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a pending response stays until taken
   `SSW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")

   // a stalled response keeps its data
   `SSW_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "response data changed while stalled")

   // no response straight out of reset
   `SSW_ASSERT_NEXT_ALWAYS(a_rst_rsp, clock, reset, !rsp_tvalid, "response valid after reset")

   // the clearing pass after reset blocks requests
   `SSW_ASSERT_NEXT_ALWAYS(a_rst_block, clock, reset, !req_tready, "request taken during clearing pass")

endmodule

bind sliding_sequence_window_bitmap_top ssw_checker u_ssw_checker (.*);

FILE: tb/sv/seq_window_checker.sv
// Watches both streams of the sequence window bitmap, predicts each test answer and compares.
module seq_window_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seq_number
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] is_seen, [7:1] zero
   output int          mismatch_count,
   output int          pending_count
);

   localparam int          WORDS = ssw_pkg::WINDOW_WORDS_DEF;
   localparam logic [31:0] SPAN  = 32'(WORDS * 32);

   // predicted window contents
   logic [31:0] flag_rows [WORDS];
   logic [31:0] floor_seq;
   // answers still owed by the block, oldest first
   bit          seen_answers [$];

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   // serial-number order: a precedes b
   function automatic bit seq_precedes(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = b - a;
      return (d != 32'd0) && (d < 32'h8000_0000);
   endfunction

   function automatic bit predict_seen(input logic [31:0] seq);
      logic [31:0] rel;
      rel = seq - floor_seq;
      if (seq_precedes(seq, floor_seq)) return 1'b1;
      if (!seq_precedes(seq, floor_seq + SPAN)) return 1'b0;
      if ((rel >> 5) >= WORDS) return 1'b0;
      return flag_rows[rel >> 5][seq[4:0]];
   endfunction

   task automatic wipe_window();
      for (int i = 0; i < WORDS; i++) flag_rows[i] = '0;
      floor_seq = '0;
   endtask

   task automatic record_mark(input logic [31:0] seq);
      logic [31:0] rel;
      logic [31:0] move;
      logic [31:0] old_rows [WORDS];
      if (seq_precedes(seq, floor_seq)) return;
      rel = seq - floor_seq;
      // past the ceiling: slide so that seq lands in the top word
      if (!seq_precedes(seq, floor_seq + SPAN)) begin
         move = (rel >> 5) - (WORDS - 1);
         old_rows = flag_rows;
         for (int i = 0; i < WORDS; i++) begin
            if (move < WORDS - i) flag_rows[i] = old_rows[i + move];
            else flag_rows[i] = '0;
         end
         floor_seq = floor_seq + (move << 5);
         rel = seq - floor_seq;
      end
      if ((rel >> 5) < WORDS) flag_rows[rel >> 5][seq[4:0]] = 1'b1;
   endtask

   task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
      if (mismatch_count < 10)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      mismatch_count++;
   endtask

   // result transfers are checked before the request of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         wipe_window();
         seen_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (seen_answers.size() == 0) begin
               note_mismatch("response with none expected", 8'h00, rsp_tdata);
            end else begin
               bit want;
               want = seen_answers.pop_front();
               if (rsp_tdata[0] !== want) note_mismatch("is_seen", {7'd0, want}, rsp_tdata);
               if (rsp_tdata[7:1] !== 7'd0) note_mismatch("padding", 8'h00, rsp_tdata);
            end
         end
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ssw_pkg::KIND_TEST:  seen_answers.push_back(predict_seen(req_tdata));
               ssw_pkg::KIND_MARK:  record_mark(req_tdata);
               ssw_pkg::KIND_CLEAR: wipe_window();
               default: ;
            endcase
         end
      end
      pending_count <= seen_answers.size();
   end

endmodule

FILE: tb/sv/testbench.sv
// Top of the sequence window bitmap testbench: clock, reset, stimulus and verdict.
module testbench;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         DRAIN_CYCLES = 2 * ssw_pkg::WINDOW_WORDS_DEF + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   int          mismatch_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          calm = 1'b0;

   sliding_sequence_window_bitmap_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   seq_window_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 13);
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // one request transfer; entered and left at a falling edge
   task automatic send_item(input logic [1:0] kind, input logic [31:0] seq);
      while (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= seq;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] cursor;
      logic [31:0] seq;
      int unsigned pick;
      int unsigned hop;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty window, edges of the window, slides, wrap, half-space, clear
      send_item(ssw_pkg::KIND_TEST, 32'd0);
      send_item(ssw_pkg::KIND_MARK, 32'd0);
      send_item(ssw_pkg::KIND_TEST, 32'd0);
      send_item(ssw_pkg::KIND_MARK, 32'd31);
      send_item(ssw_pkg::KIND_TEST, 32'd31);
      send_item(ssw_pkg::KIND_TEST, 32'd30);
      send_item(ssw_pkg::KIND_MARK, 32'd255);
      send_item(ssw_pkg::KIND_TEST, 32'd255);
      send_item(ssw_pkg::KIND_TEST, 32'd256);
      send_item(ssw_pkg::KIND_MARK, 32'd256);
      send_item(ssw_pkg::KIND_TEST, 32'd0);
      send_item(ssw_pkg::KIND_TEST, 32'd256);
      send_item(ssw_pkg::KIND_MARK, 32'hFFFF_FFFF);
      send_item(ssw_pkg::KIND_TEST, 32'hFFFF_FFFF);
      send_item(ssw_pkg::KIND_TEST, 32'h8000_0020);
      send_item(ssw_pkg::KIND_TEST, 32'h8000_0120);
      send_item(ssw_pkg::KIND_MARK, 32'h8000_0020);
      send_item(ssw_pkg::KIND_TEST, 32'h8000_0020);
      send_item(ssw_pkg::KIND_TEST, 32'h0000_0020);
      send_item(KIND_UNUSED, 32'hFFFF_FFFF);
      send_item(ssw_pkg::KIND_TEST, 32'h8000_0020);
      send_item(ssw_pkg::KIND_CLEAR, 32'hAAAA_5555);
      send_item(ssw_pkg::KIND_TEST, 32'h8000_0020);
      send_item(ssw_pkg::KIND_TEST, 32'd0);
      send_item(ssw_pkg::KIND_MARK, 32'hFFFF_FF00);

      // random: mostly near a drifting cursor, some far and wrapping values
      cursor = 32'hFFFF_FF00;
      for (int n = 0; n < 1100; n++) begin
         calm = (n >= 400) && (n < 650);
         hop = $urandom_range(99);
         if (hop < 8) cursor = cursor + $urandom_range(1, 48);
         else if (hop < 10) cursor = cursor + $urandom_range(256, 4096);
         else if (hop == 10) cursor = $urandom();
         else if (hop == 11) cursor = 32'hFFFF_FFFF - $urandom_range(0, 300);
         if ($urandom_range(19) == 0) seq = $urandom();
         else seq = cursor + $urandom_range(0, 383) - 32'd64;
         pick = $urandom_range(99);
         if (pick < 46) begin
            send_item(ssw_pkg::KIND_TEST, seq);
         end else if (pick < 92) begin
            send_item(ssw_pkg::KIND_MARK, seq);
         end else if (pick < 96) begin
            send_item(ssw_pkg::KIND_CLEAR, seq);
            if ($urandom_range(1) == 1) cursor = '0;
         end else begin
            send_item(KIND_UNUSED, seq);
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain: every answer in, then let a trailing slide or clear finish
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
